@@ rtl/dfp_pkg.sv @@
// ----------------------------------------------------------------------------
// dfp_pkg
// Shared constants and types of the DHCP message type parser.
// ----------------------------------------------------------------------------
package dfp_pkg;

    localparam int DEF_MAX_FRAME_BYTES = 2048;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_FRAME_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLIENT_ADDR_OFFSET = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPTIONS_OFFSET     = 2'd2;

    localparam logic [10:0] RST_MIN_FRAME_LENGTH   = 11'd285;
    localparam logic [7:0]  RST_CLIENT_ADDR_OFFSET = 8'd16;
    localparam logic [7:0]  RST_OPTIONS_OFFSET     = 8'd240;
    localparam logic [5:0]  RST_IP_HEADER_BYTES    = 6'd20;

    localparam int ETH_HDR_BYTES = 14;
    localparam int UDP_HDR_BYTES = 8;
    localparam int OPT_HDR_BYTES = 2;
    localparam int ADDR_BYTES    = 4;

    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_END      = 8'd255;
    localparam logic [7:0] TYPE_ACK     = 8'd5;
    localparam logic [7:0] TYPE_RELEASE = 8'd7;

    typedef enum logic [1:0] {
        ACT_IGNORE  = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_SHORT   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        PH_CODE  = 3'b001,
        PH_LEN   = 3'b010,
        PH_VALUE = 3'b100
    } t_phase;

    typedef struct packed {
        logic       last;
        logic [7:0] frame_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] client_address;
        logic [7:0]  message_type;
        t_action     action;
    } t_result;

endpackage

@@ rtl/dfp_in_stage.sv @@
// ----------------------------------------------------------------------------
// dfp_in_stage
// Input register: holds one frame byte until the parser takes it.
// ----------------------------------------------------------------------------
module dfp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dfp_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_valid,
    output dfp_pkg::t_in_item o_item
);
    import dfp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ rtl/dfp_parser.sv @@
// ----------------------------------------------------------------------------
// dfp_parser
// Per-byte frame walk: header skip, address capture, option search, verdict.
// ----------------------------------------------------------------------------
module dfp_parser #(
    parameter int MAX_FRAME_BYTES = dfp_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dfp_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [dfp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    input  dfp_pkg::t_in_item                   i_item,
    input  logic                                i_out_free,
    output logic                                o_take,
    output logic                                o_res_valid,
    output dfp_pkg::t_result                    o_res
);
    import dfp_pkg::*;

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int NW = $clog2(MAX_FRAME_BYTES);
    localparam int SW = PW + 1;
    localparam logic [SW-1:0] MAX_S = SW'(MAX_FRAME_BYTES);

    logic [10:0]   r_min_len;
    logic [7:0]    r_caddr_off;
    logic [7:0]    r_opt_off;

    logic [PW-1:0] r_pos,   n_pos;
    logic [5:0]    r_ihl,   n_ihl;
    logic [NW-1:0] r_next,  n_next;
    t_phase        r_phase, n_phase;
    logic [7:0]    r_found, n_found;
    logic          r_done,  n_done;
    logic [31:0]   r_addr,  n_addr;

    logic [7:0]    b;
    logic [SW-1:0] pos_s;
    logic [SW-1:0] dhcp_start;
    logic [SW-1:0] opt_start;
    logic [SW-1:0] addr_start;
    logic [SW-1:0] addr_diff;
    logic [SW-1:0] tgt;
    logic          set_req;
    logic [7:0]    res_type;
    t_action       res_action;

    assign b      = i_item.frame_byte;
    assign o_take = i_valid && (!i_item.last || i_out_free);

    always_comb begin
        n_pos      = r_pos;
        n_ihl      = r_ihl;
        n_next     = r_next;
        n_phase    = r_phase;
        n_found    = r_found;
        n_done     = r_done;
        n_addr     = r_addr;
        set_req    = 1'b0;
        tgt        = '0;
        pos_s      = SW'(r_pos);
        dhcp_start = SW'(ETH_HDR_BYTES) + SW'(r_ihl) + SW'(UDP_HDR_BYTES);
        opt_start  = SW'(ETH_HDR_BYTES) + SW'({b[3:0], 2'b00}) + SW'(UDP_HDR_BYTES)
                   + SW'(r_opt_off);
        addr_start = dhcp_start + SW'(r_caddr_off);
        addr_diff  = pos_s - addr_start;

        if (pos_s < MAX_S) begin
            if (pos_s == SW'(ETH_HDR_BYTES)) begin
                n_ihl   = {b[3:0], 2'b00};
                set_req = 1'b1;
                tgt     = opt_start;
            end else if (pos_s > SW'(ETH_HDR_BYTES)) begin
                if (pos_s >= addr_start && addr_diff < SW'(ADDR_BYTES)) begin
                    n_addr = {r_addr[23:0], b};
                end
                if (!r_done && pos_s == SW'(r_next)) begin
                    case (r_phase)
                        PH_CODE: begin
                            if (b == OPT_MSG_TYPE) begin
                                n_phase = PH_VALUE;
                                set_req = 1'b1;
                                tgt     = pos_s + SW'(OPT_HDR_BYTES);
                            end else if (b == OPT_END) begin
                                n_done  = 1'b1;
                                n_found = '0;
                            end else if (b == OPT_PAD) begin
                                set_req = 1'b1;
                                tgt     = pos_s + SW'(1);
                            end else begin
                                n_phase = PH_LEN;
                                set_req = 1'b1;
                                tgt     = pos_s + SW'(1);
                            end
                        end
                        PH_LEN: begin
                            n_phase = PH_CODE;
                            set_req = 1'b1;
                            tgt     = pos_s + SW'(1) + SW'(b);
                        end
                        PH_VALUE: begin
                            n_found = b;
                            n_done  = 1'b1;
                        end
                        default: begin
                            n_phase = PH_CODE;
                        end
                    endcase
                end
            end
            n_pos = r_pos + PW'(1);
        end

        if (set_req) begin
            if (tgt >= MAX_S) begin
                n_done  = 1'b1;
                n_found = '0;
            end else begin
                n_next = tgt[NW-1:0];
            end
        end

        res_type = n_done ? n_found : 8'd0;
        if (SW'(n_pos) < SW'(r_min_len)) begin
            res_action = ACT_SHORT;
        end else if (n_done && res_type == TYPE_ACK) begin
            res_action = ACT_ACK;
        end else if (n_done && res_type == TYPE_RELEASE) begin
            res_action = ACT_RELEASE;
        end else begin
            res_action = ACT_IGNORE;
        end
    end

    assign o_res_valid          = o_take && i_item.last;
    assign o_res.action         = res_action;
    assign o_res.message_type   = res_type;
    assign o_res.client_address = n_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len   <= RST_MIN_FRAME_LENGTH;
            r_caddr_off <= RST_CLIENT_ADDR_OFFSET;
            r_opt_off   <= RST_OPTIONS_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_FRAME_LENGTH:   r_min_len   <= i_cfg_data;
                CFG_CLIENT_ADDR_OFFSET: r_caddr_off <= i_cfg_data[7:0];
                CFG_OPTIONS_OFFSET:     r_opt_off   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && i_item.last)) begin
            r_pos   <= '0;
            r_ihl   <= RST_IP_HEADER_BYTES;
            r_next  <= '0;
            r_phase <= PH_CODE;
            r_found <= '0;
            r_done  <= 1'b0;
            r_addr  <= '0;
        end else if (o_take) begin
            r_pos   <= n_pos;
            r_ihl   <= n_ihl;
            r_next  <= n_next;
            r_phase <= n_phase;
            r_found <= n_found;
            r_done  <= n_done;
            r_addr  <= n_addr;
        end
    end

endmodule

@@ rtl/dfp_out_stage.sv @@
// ----------------------------------------------------------------------------
// dfp_out_stage
// Result register: holds one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module dfp_out_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_res_valid,
    input  dfp_pkg::t_result                  i_res,
    output logic                              o_free,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [dfp_pkg::OUT_TDATA_W-1:0]   o_data
);
    import dfp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = OUT_TDATA_W'(r_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

@@ rtl/dhcp_frame_message_type_parser_core.sv @@
// ----------------------------------------------------------------------------
// dhcp_frame_message_type_parser_core
// Byte-serial Ethernet frame parser reporting the DHCP message type verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one frame byte per item in tdata, tlast on the final byte.
//   Master stream: one verdict item per frame, sent after its tlast byte.
//   Configuration: write enable, register index and data; write only while
//   no frame is in flight.
//   Path: an accepted last byte passes the input register, then the result
//   register, before its verdict is valid.
//   Throughput: 1 byte per cycle unless a last byte waits on a held verdict;
//   each byte passes one compare-and-count stage between the input and result registers.
//   Reset: clears both registers and the frame walk; configuration returns
//   to minimum length 285, address offset 16, options offset 240.
//   Stall: a held verdict does not block ordinary bytes; only the next
//   last byte waits in the input register until the verdict is taken.
// ----------------------------------------------------------------------------
module dhcp_frame_message_type_parser_core #(
    parameter int MAX_FRAME_BYTES = dfp_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dfp_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [dfp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [dfp_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // [7:0] frame_byte
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [1:0] action, [9:2] message_type, [41:10] client_address, [47:42] zero
    output logic [dfp_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import dfp_pkg::*;

    t_in_item in_item;
    t_in_item stage_item;
    t_result  res;
    logic     stage_valid;
    logic     take;
    logic     res_valid;
    logic     out_free;

    assign in_item.frame_byte = i_s_axis_tdata;
    assign in_item.last       = i_s_axis_tlast;

    dfp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    dfp_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    dfp_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("verdict overwrites a held item");

    a_res_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (take && stage_item.last))
        else $error("verdict without a consumed last byte");

    a_ack_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[1:0] == ACT_ACK)
            |-> (o_m_axis_tdata[9:2] == TYPE_ACK))
        else $error("acknowledge verdict with wrong message type");

    a_rel_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[1:0] == ACT_RELEASE)
            |-> (o_m_axis_tdata[9:2] == TYPE_RELEASE))
        else $error("release verdict with wrong message type");

endmodule
